// File: hdl/cbr_pkg.sv
package cbr_pkg;

    // Field and register widths
    localparam int unsigned OP_W       = 3;
    localparam int unsigned CH_W       = 3;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 64;
    localparam int unsigned JIT_W      = 64;
    localparam int unsigned DELAY_W    = 16;
    localparam int unsigned ATT_W      = 7;
    localparam int unsigned PHASE_W    = 2;
    localparam int unsigned CNT_W      = 32;

    // Datapath widths
    localparam int unsigned SHIFT_W  = 3;
    localparam int unsigned UNJ_W    = DELAY_W + 6;   // base << 6
    localparam int unsigned FOLD_W   = 22;            // sum of three 20-bit chunks and a 4-bit top chunk
    localparam int unsigned MODT_W   = 12;            // biased residue before mod 41
    localparam int unsigned FACTOR_W = 7;             // 80..120
    localparam int unsigned PROD_W   = DELAY_W + FACTOR_W;
    localparam int unsigned RECIP_W  = 24;
    localparam int unsigned DIVP_W   = PROD_W + RECIP_W;
    localparam int unsigned QUOT_W   = 17;
    localparam int unsigned DIV_SHIFT = 30;

    // Operation codes
    localparam logic [OP_W-1:0] OP_CONNECTED    = 3'd0;
    localparam logic [OP_W-1:0] OP_FAILURE      = 3'd1;
    localparam logic [OP_W-1:0] OP_AGG_FAILURE  = 3'd2;
    localparam logic [OP_W-1:0] OP_RECONNECTING = 3'd3;

    // Phase codes
    localparam logic [PHASE_W-1:0] PHASE_CONNECTED    = 2'd0;
    localparam logic [PHASE_W-1:0] PHASE_DEGRADED     = 2'd1;
    localparam logic [PHASE_W-1:0] PHASE_RECONNECTING = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_JITTER_SEED = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_DELAY  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DELAY   = 2'd2;

    localparam logic [JIT_W-1:0]   SEED_RESET   = 64'h9e3779b97f4a7c15;
    localparam logic [JIT_W-1:0]   SEED_IF_ZERO = 64'h9e3779b97f4a7c15;
    localparam logic [JIT_W-1:0]   STATE_IF_ZERO = 64'hd1b54a32d192ed03;
    localparam logic [DELAY_W-1:0] BASE_RESET   = 16'd100;
    localparam logic [DELAY_W-1:0] MAX_RESET    = 16'd5000;

    localparam logic [ATT_W-1:0]    ATT_MAX     = 7'd64;
    localparam logic [SHIFT_W-1:0]  SHIFT_MAX   = 3'd6;
    localparam logic [FACTOR_W-1:0] FACTOR_BASE = 7'd80;

    // r mod 41: 2^10 == -1 (mod 41), reciprocal 1599 / 2^16 is exact below 2849
    localparam logic [MODT_W-1:0] MOD_BIAS    = 12'd1025;
    localparam logic [10:0]       MOD_RECIP   = 11'd1599;
    localparam int unsigned       MOD_SHIFT   = 16;
    localparam logic [MODT_W-1:0] MOD_DIVISOR = 12'd41;

    // x / 100 as (x * ceil(2^30 / 100)) >> 30, exact for x < 14e6
    localparam logic [RECIP_W-1:0] DIV_RECIP = 24'd10737419;

    typedef struct packed {
        logic capture;
        logic prep;
        logic mod;
        logic scale;
        logic div;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic is_fail;
    } t_status;

    function automatic logic [JIT_W-1:0] xorshift(input logic [JIT_W-1:0] s);
        logic [JIT_W-1:0] v;
        v = s ^ (s << 13);
        v = v ^ (v >> 7);
        v = v ^ (v << 17);
        return v;
    endfunction

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == '1) ? v : v + CNT_W'(1);
    endfunction

endpackage

// File: hdl/channel_reconnect_backoff_core.sv
// Reconnect backoff tracker for a table of channels. Pulse i_start with an
// operation and a channel while o_busy is low; the event is taken on that
// edge and o_busy rises. Exactly one result beat follows: o_done is high for
// a single cycle and the result ports are valid only in that cycle, so the
// receiver must take it then - there is no way to hold it off. Connected,
// reconnecting, query and out-of-range events pass through the prep and
// commit states; failures also run the jitter chain (mod-41 reduction, one
// scaling multiply, one reciprocal multiply for the divide by 100), each a
// registered step. o_busy is already low in the cycle that shows o_done, so
// a new event may be issued there. Configuration writes (i_cfg_we with
// i_cfg_index 0 seed, 1 base delay, 2 max delay) take effect at once and
// are meant for idle periods only; other indexes are ignored.
module channel_reconnect_backoff_core #(
    parameter int unsigned NUM_CHANNELS = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    output logic                                o_busy,
    input  logic [cbr_pkg::OP_W-1:0]            i_operation,
    input  logic [cbr_pkg::CH_W-1:0]            i_channel,
    input  logic                                i_cfg_we,
    input  logic [cbr_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [cbr_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    output logic                                o_done,
    output logic                                o_recovered,
    output logic [cbr_pkg::PHASE_W-1:0]         o_phase,
    output logic [cbr_pkg::ATT_W-1:0]           o_attempts,
    output logic [cbr_pkg::DELAY_W-1:0]         o_retry_delay_ms,
    output logic [cbr_pkg::CNT_W-1:0]           o_interruptions,
    output logic [cbr_pkg::CNT_W-1:0]           o_recoveries,
    output logic [cbr_pkg::CNT_W-1:0]           o_metered_failures
);

    // Controller sequences the steps; datapath owns the table and arithmetic
    cbr_pkg::t_cmd    w_cmd;
    cbr_pkg::t_status w_status;

    cbr_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_status (w_status),
        .o_cmd    (w_cmd),
        .o_busy   (o_busy)
    );

    // Each result beat leaves the datapath output registers directly
    cbr_datapath #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_datapath (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cmd                (w_cmd),
        .o_status             (w_status),
        .i_operation          (i_operation),
        .i_channel            (i_channel),
        .i_cfg_we             (i_cfg_we),
        .i_cfg_index          (i_cfg_index),
        .i_cfg_data           (i_cfg_data),
        .o_done               (o_done),
        .o_recovered          (o_recovered),
        .o_phase              (o_phase),
        .o_attempts           (o_attempts),
        .o_retry_delay_ms     (o_retry_delay_ms),
        .o_interruptions      (o_interruptions),
        .o_recoveries         (o_recoveries),
        .o_metered_failures   (o_metered_failures)
    );

endmodule

// File: hdl/cbr_ctrl.sv
module cbr_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  cbr_pkg::t_status i_status,
    output cbr_pkg::t_cmd    o_cmd,
    output logic             o_busy
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_MOD,
        S_SCALE,
        S_DIV,
        S_COMMIT
    } t_state;

    t_state r_state, n_state;
    logic   r_busy,  n_busy;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   n_state = i_start ? S_PREP : S_IDLE;
            S_PREP:   n_state = i_status.is_fail ? S_MOD : S_COMMIT;
            S_MOD:    n_state = S_SCALE;
            S_SCALE:  n_state = S_DIV;
            S_DIV:    n_state = S_COMMIT;
            S_COMMIT: n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
        n_busy = (n_state != S_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= n_busy;
        end
    end

    assign o_cmd.capture = (r_state == S_IDLE) && i_start;
    assign o_cmd.prep    = (r_state == S_PREP);
    assign o_cmd.mod     = (r_state == S_MOD);
    assign o_cmd.scale   = (r_state == S_SCALE);
    assign o_cmd.div     = (r_state == S_DIV);
    assign o_cmd.commit  = (r_state == S_COMMIT);
    assign o_busy        = r_busy;

endmodule

// File: hdl/cbr_datapath.sv
module cbr_datapath #(
    parameter int unsigned NUM_CHANNELS = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  cbr_pkg::t_cmd                       i_cmd,
    output cbr_pkg::t_status                    o_status,
    input  logic [cbr_pkg::OP_W-1:0]            i_operation,
    input  logic [cbr_pkg::CH_W-1:0]            i_channel,
    input  logic                                i_cfg_we,
    input  logic [cbr_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [cbr_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    output logic                                o_done,
    output logic                                o_recovered,
    output logic [cbr_pkg::PHASE_W-1:0]         o_phase,
    output logic [cbr_pkg::ATT_W-1:0]           o_attempts,
    output logic [cbr_pkg::DELAY_W-1:0]         o_retry_delay_ms,
    output logic [cbr_pkg::CNT_W-1:0]           o_interruptions,
    output logic [cbr_pkg::CNT_W-1:0]           o_recoveries,
    output logic [cbr_pkg::CNT_W-1:0]           o_metered_failures
);

    // Only channels reachable through the channel field get an entry
    localparam int unsigned CH_SPAN = 1 << cbr_pkg::CH_W;
    localparam int unsigned NCH     = (NUM_CHANNELS < CH_SPAN) ? NUM_CHANNELS : CH_SPAN;
    localparam int unsigned IDX_W   = (NCH > 1) ? $clog2(NCH) : 1;

    // Configuration
    logic [cbr_pkg::JIT_W-1:0]   r_cfg_seed;
    logic [cbr_pkg::DELAY_W-1:0] r_cfg_base;
    logic [cbr_pkg::DELAY_W-1:0] r_cfg_max;

    // Channel table
    logic                          r_seeded [NCH];
    logic [cbr_pkg::PHASE_W-1:0]   r_phase  [NCH];
    logic [cbr_pkg::ATT_W-1:0]     r_att    [NCH];
    logic [cbr_pkg::DELAY_W-1:0]   r_delay  [NCH];
    logic                          r_outage [NCH];
    logic [cbr_pkg::JIT_W-1:0]     r_jit    [NCH];
    logic [cbr_pkg::CNT_W-1:0]     r_int    [NCH];
    logic [cbr_pkg::CNT_W-1:0]     r_rec    [NCH];
    logic [cbr_pkg::CNT_W-1:0]     r_total;

    // Event and pipeline registers
    logic [cbr_pkg::OP_W-1:0]     r_op;
    logic [cbr_pkg::CH_W-1:0]     r_ch;
    logic [cbr_pkg::JIT_W-1:0]    r_jit_next;
    logic [cbr_pkg::ATT_W-1:0]    r_att_next;
    logic [cbr_pkg::DELAY_W-1:0]  r_unj;
    logic [cbr_pkg::FOLD_W-1:0]   r_fold;
    logic [cbr_pkg::FACTOR_W-1:0] r_factor;
    logic [cbr_pkg::PROD_W-1:0]   r_prod;
    logic [cbr_pkg::QUOT_W-1:0]   r_quot;

    // Result registers
    logic                         r_done;
    logic                         r_recovered_out;
    logic [cbr_pkg::PHASE_W-1:0]  r_phase_out;
    logic [cbr_pkg::ATT_W-1:0]    r_att_out;
    logic [cbr_pkg::DELAY_W-1:0]  r_delay_out;
    logic [cbr_pkg::CNT_W-1:0]    r_int_out;
    logic [cbr_pkg::CNT_W-1:0]    r_rec_out;
    logic [cbr_pkg::CNT_W-1:0]    r_total_out;

    logic                         w_in_range;
    logic                         w_is_fail;
    logic [IDX_W-1:0]             w_idx;
    logic                         w_seeded;
    logic [cbr_pkg::PHASE_W-1:0]  w_phase;
    logic [cbr_pkg::ATT_W-1:0]    w_att;
    logic [cbr_pkg::DELAY_W-1:0]  w_delay_cur;
    logic                         w_outage;
    logic [cbr_pkg::CNT_W-1:0]    w_int;
    logic [cbr_pkg::CNT_W-1:0]    w_rec;
    logic [cbr_pkg::JIT_W-1:0]    w_seed_base;
    logic [cbr_pkg::JIT_W-1:0]    w_seed_mix;
    logic [cbr_pkg::JIT_W-1:0]    w_seed_init;
    logic [cbr_pkg::JIT_W-1:0]    w_jit_cur;
    logic [cbr_pkg::JIT_W-1:0]    w_jit_step;
    logic [cbr_pkg::ATT_W-1:0]    w_att_next;
    logic [cbr_pkg::ATT_W-1:0]    w_att_m1;
    logic [cbr_pkg::SHIFT_W-1:0]  w_shift;
    logic [cbr_pkg::UNJ_W-1:0]    w_base_sh;
    logic [cbr_pkg::DELAY_W-1:0]  w_unj;
    logic [cbr_pkg::FOLD_W-1:0]   w_fold;
    logic [cbr_pkg::MODT_W-1:0]   w_modt;
    logic [22:0]                  w_modq_full;
    logic [cbr_pkg::MODT_W-1:0]   w_modq;
    logic [cbr_pkg::MODT_W-1:0]   w_modr;
    logic [cbr_pkg::DIVP_W-1:0]   w_div_full;
    logic [cbr_pkg::QUOT_W-1:0]   w_delay_lo;
    logic [cbr_pkg::DELAY_W-1:0]  w_delay_new;

    logic                         n_seeded;
    logic [cbr_pkg::PHASE_W-1:0]  n_phase;
    logic [cbr_pkg::ATT_W-1:0]    n_att;
    logic [cbr_pkg::DELAY_W-1:0]  n_delay;
    logic                         n_outage;
    logic [cbr_pkg::JIT_W-1:0]    n_jit;
    logic [cbr_pkg::CNT_W-1:0]    n_int;
    logic [cbr_pkg::CNT_W-1:0]    n_rec;
    logic [cbr_pkg::CNT_W-1:0]    n_total;
    logic                         n_recovered;

    assign w_in_range = (32'(r_ch) < NUM_CHANNELS);
    assign w_is_fail  = w_in_range &&
                        ((r_op == cbr_pkg::OP_FAILURE) || (r_op == cbr_pkg::OP_AGG_FAILURE));
    assign o_status.is_fail = w_is_fail;

    assign w_idx       = r_ch[IDX_W-1:0];
    assign w_seeded    = r_seeded[w_idx];
    assign w_phase     = r_phase[w_idx];
    assign w_att       = r_att[w_idx];
    assign w_delay_cur = r_delay[w_idx];
    assign w_outage    = r_outage[w_idx];
    assign w_int       = r_int[w_idx];
    assign w_rec       = r_rec[w_idx];

    // First-use seed, then one generator step
    assign w_seed_base = (r_cfg_seed == '0) ? cbr_pkg::SEED_IF_ZERO : r_cfg_seed;
    assign w_seed_mix  = w_seed_base ^ cbr_pkg::JIT_W'(r_ch);
    assign w_seed_init = (w_seed_mix == '0) ? cbr_pkg::STATE_IF_ZERO : w_seed_mix;
    assign w_jit_cur   = w_seeded ? r_jit[w_idx] : w_seed_init;
    assign w_jit_step  = cbr_pkg::xorshift(w_jit_cur);

    // Unjittered delay: min(max, base << min(attempt - 1, 6))
    assign w_att_next = (w_att < cbr_pkg::ATT_MAX) ? w_att + cbr_pkg::ATT_W'(1) : w_att;
    assign w_att_m1   = w_att_next - cbr_pkg::ATT_W'(1);
    assign w_shift    = (w_att_m1 > cbr_pkg::ATT_W'(cbr_pkg::SHIFT_MAX)) ?
                        cbr_pkg::SHIFT_MAX : w_att_m1[cbr_pkg::SHIFT_W-1:0];
    assign w_base_sh  = cbr_pkg::UNJ_W'(r_cfg_base) << w_shift;
    assign w_unj      = (w_base_sh > cbr_pkg::UNJ_W'(r_cfg_max)) ?
                        r_cfg_max : w_base_sh[cbr_pkg::DELAY_W-1:0];

    // 2^20 == 1 (mod 41): fold the sample into 20-bit chunks
    assign w_fold = cbr_pkg::FOLD_W'(w_jit_step[19:0])  + cbr_pkg::FOLD_W'(w_jit_step[39:20]) +
                    cbr_pkg::FOLD_W'(w_jit_step[59:40]) + cbr_pkg::FOLD_W'(w_jit_step[63:60]);

    // Fold again with 2^10 == -1, bias keeps it positive, then reciprocal divide
    assign w_modt      = cbr_pkg::MODT_W'(r_fold[9:0]) + cbr_pkg::MODT_W'(r_fold[21:20]) +
                         cbr_pkg::MOD_BIAS - cbr_pkg::MODT_W'(r_fold[19:10]);
    assign w_modq_full = 23'(w_modt) * 23'(cbr_pkg::MOD_RECIP);
    assign w_modq      = cbr_pkg::MODT_W'(w_modq_full[22:cbr_pkg::MOD_SHIFT]);
    assign w_modr      = w_modt - cbr_pkg::MODT_W'(w_modq * cbr_pkg::MOD_DIVISOR);

    assign w_div_full  = cbr_pkg::DIVP_W'(r_prod) * cbr_pkg::DIVP_W'(cbr_pkg::DIV_RECIP);

    // Clamp low to 1 first, then high to max
    assign w_delay_lo  = (r_quot == '0) ? cbr_pkg::QUOT_W'(1) : r_quot;
    assign w_delay_new = (w_delay_lo > cbr_pkg::QUOT_W'(r_cfg_max)) ?
                         r_cfg_max : w_delay_lo[cbr_pkg::DELAY_W-1:0];

    always_comb begin
        n_seeded    = w_seeded;
        n_phase     = w_phase;
        n_att       = w_att;
        n_delay     = w_delay_cur;
        n_outage    = w_outage;
        n_jit       = r_jit[w_idx];
        n_int       = w_int;
        n_rec       = w_rec;
        n_total     = r_total;
        n_recovered = 1'b0;
        if (r_op <= cbr_pkg::OP_RECONNECTING) begin
            n_seeded = 1'b1;
            n_jit    = w_jit_cur;
        end
        case (r_op)
            cbr_pkg::OP_CONNECTED: begin
                n_recovered = w_outage;
                if (w_outage) begin
                    n_rec = cbr_pkg::sat_inc(w_rec);
                end
                n_phase  = cbr_pkg::PHASE_CONNECTED;
                n_att    = '0;
                n_delay  = '0;
                n_outage = 1'b0;
            end
            cbr_pkg::OP_FAILURE, cbr_pkg::OP_AGG_FAILURE: begin
                if (!w_outage) begin
                    n_int = cbr_pkg::sat_inc(w_int);
                end
                n_outage = 1'b1;
                n_att    = r_att_next;
                n_phase  = (r_att_next == cbr_pkg::ATT_W'(1)) ?
                           cbr_pkg::PHASE_DEGRADED : cbr_pkg::PHASE_RECONNECTING;
                n_jit    = r_jit_next;
                n_delay  = w_delay_new;
                if (r_op == cbr_pkg::OP_FAILURE) begin
                    n_total = cbr_pkg::sat_inc(r_total);
                end
            end
            cbr_pkg::OP_RECONNECTING: begin
                n_phase = cbr_pkg::PHASE_RECONNECTING;
            end
            default: begin
                n_phase = w_phase;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_seed <= cbr_pkg::SEED_RESET;
            r_cfg_base <= cbr_pkg::BASE_RESET;
            r_cfg_max  <= cbr_pkg::MAX_RESET;
            r_total    <= '0;
            r_done     <= 1'b0;
            for (int i = 0; i < NCH; i++) begin
                r_seeded[i] <= 1'b0;
                r_phase[i]  <= cbr_pkg::PHASE_CONNECTED;
                r_att[i]    <= '0;
                r_delay[i]  <= '0;
                r_outage[i] <= 1'b0;
                r_int[i]    <= '0;
                r_rec[i]    <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    cbr_pkg::CFG_JITTER_SEED: r_cfg_seed <= i_cfg_data;
                    cbr_pkg::CFG_BASE_DELAY:  r_cfg_base <= i_cfg_data[cbr_pkg::DELAY_W-1:0];
                    cbr_pkg::CFG_MAX_DELAY:   r_cfg_max  <= i_cfg_data[cbr_pkg::DELAY_W-1:0];
                    default:                  r_cfg_seed <= r_cfg_seed;
                endcase
            end
            r_done <= i_cmd.commit;
            if (i_cmd.commit && w_in_range) begin
                r_seeded[w_idx] <= n_seeded;
                r_phase[w_idx]  <= n_phase;
                r_att[w_idx]    <= n_att;
                r_delay[w_idx]  <= n_delay;
                r_outage[w_idx] <= n_outage;
                r_int[w_idx]    <= n_int;
                r_rec[w_idx]    <= n_rec;
                r_total         <= n_total;
            end
        end
    end

    // Payload: generator state is meaningful only once seeded
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op <= i_operation;
            r_ch <= i_channel;
        end
        if (i_cmd.prep) begin
            r_jit_next <= w_jit_step;
            r_att_next <= w_att_next;
            r_unj      <= w_unj;
            r_fold     <= w_fold;
        end
        if (i_cmd.mod) begin
            r_factor <= cbr_pkg::FACTOR_BASE + cbr_pkg::FACTOR_W'(w_modr);
        end
        if (i_cmd.scale) begin
            r_prod <= cbr_pkg::PROD_W'(r_unj) * cbr_pkg::PROD_W'(r_factor);
        end
        if (i_cmd.div) begin
            r_quot <= w_div_full[cbr_pkg::DIV_SHIFT +: cbr_pkg::QUOT_W];
        end
        if (i_cmd.commit && w_in_range) begin
            r_jit[w_idx] <= n_jit;
        end
        if (i_cmd.commit) begin
            r_total_out <= w_in_range ? n_total : r_total;
            if (w_in_range) begin
                r_recovered_out <= n_recovered;
                r_phase_out     <= n_phase;
                r_att_out       <= n_att;
                r_delay_out     <= n_delay;
                r_int_out       <= n_int;
                r_rec_out       <= n_rec;
            end else begin
                r_recovered_out <= 1'b0;
                r_phase_out     <= cbr_pkg::PHASE_CONNECTED;
                r_att_out       <= '0;
                r_delay_out     <= '0;
                r_int_out       <= '0;
                r_rec_out       <= '0;
            end
        end
    end

    assign o_done               = r_done;
    assign o_recovered          = r_recovered_out;
    assign o_phase              = r_phase_out;
    assign o_attempts           = r_att_out;
    assign o_retry_delay_ms     = r_delay_out;
    assign o_interruptions      = r_int_out;
    assign o_recoveries         = r_rec_out;
    assign o_metered_failures   = r_total_out;

endmodule

// File: hdl/cbr_chk.sv
module cbr_chk (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_start,
    input logic                                o_busy,
    input logic                                o_done,
    input logic                                o_recovered,
    input logic [cbr_pkg::PHASE_W-1:0]         o_phase,
    input logic [cbr_pkg::ATT_W-1:0]           o_attempts,
    input logic [cbr_pkg::DELAY_W-1:0]         o_retry_delay_ms
);

    // An accepted event holds off the next one
    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("busy did not rise after an accepted event");

    // The result beat arrives as the block goes idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !o_busy)
        else $error("result beat while busy");

    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe longer than one cycle");

    // A connected channel carries no attempts and no delay
    a_connected_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_phase == cbr_pkg::PHASE_CONNECTED)) |->
        ((o_attempts == '0) && (o_retry_delay_ms == '0)))
        else $error("connected result with attempts or delay");

    a_recovered_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_recovered) |-> (o_phase == cbr_pkg::PHASE_CONNECTED))
        else $error("recovery reported outside connected phase");

endmodule

bind channel_reconnect_backoff_core cbr_chk u_cbr_chk (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_start          (i_start),
    .o_busy           (o_busy),
    .o_done           (o_done),
    .o_recovered      (o_recovered),
    .o_phase          (o_phase),
    .o_attempts       (o_attempts),
    .o_retry_delay_ms (o_retry_delay_ms)
);

// File: tb/backoff_snapshot_checker.sv
module backoff_snapshot_checker
    import cbr_pkg::*;
#(
    parameter int unsigned NUM_CHANNELS = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic                  i_busy,
    input  logic [OP_W-1:0]       i_operation,
    input  logic [CH_W-1:0]       i_channel,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_done,
    input  logic                  i_recovered,
    input  logic [PHASE_W-1:0]    i_phase,
    input  logic [ATT_W-1:0]      i_attempts,
    input  logic [DELAY_W-1:0]    i_retry_delay_ms,
    input  logic [CNT_W-1:0]      i_interruptions,
    input  logic [CNT_W-1:0]      i_recoveries,
    input  logic [CNT_W-1:0]      i_metered_failures,
    output int unsigned           o_mismatches,
    output int unsigned           o_pending,
    output int unsigned           o_checked,
    output int unsigned           o_peak_attempts
);

    typedef struct packed {
        logic               recovered;
        logic [PHASE_W-1:0] phase;
        logic [ATT_W-1:0]   attempts;
        logic [DELAY_W-1:0] delay_ms;
        logic [CNT_W-1:0]   interruptions;
        logic [CNT_W-1:0]   recoveries;
        logic [CNT_W-1:0]   reconnects;
    } backoff_snapshot_t;

    // Shadow copy of the channel table and the settings
    logic [JIT_W-1:0]   seed_reg;
    logic [DELAY_W-1:0] base_ms;
    logic [DELAY_W-1:0] ceiling_ms;

    logic               seeded      [NUM_CHANNELS];
    logic [PHASE_W-1:0] link_phase  [NUM_CHANNELS];
    logic [ATT_W-1:0]   tries       [NUM_CHANNELS];
    logic [DELAY_W-1:0] wait_ms     [NUM_CHANNELS];
    logic               down        [NUM_CHANNELS];
    logic [JIT_W-1:0]   rng         [NUM_CHANNELS];
    logic [CNT_W-1:0]   outages     [NUM_CHANNELS];
    logic [CNT_W-1:0]   restores    [NUM_CHANNELS];
    logic [CNT_W-1:0]   metered_fails;

    backoff_snapshot_t snapshots_due[$];
    int unsigned       mismatch_total = 0;
    int unsigned       checked_total  = 0;
    int unsigned       peak_tries     = 0;

    assign o_mismatches    = mismatch_total;
    assign o_checked       = checked_total;
    assign o_peak_attempts = peak_tries;

    function automatic logic [CNT_W-1:0] bump32(input logic [CNT_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    function automatic logic [JIT_W-1:0] jitter_advance(input logic [JIT_W-1:0] s);
        logic [JIT_W-1:0] t;
        t = s;
        t = t ^ (t << 13);
        t = t ^ (t >> 7);
        t = t ^ (t << 17);
        return t;
    endfunction

    function automatic logic [DELAY_W-1:0] backoff_ms(input logic [ATT_W-1:0] att,
                                                      input logic [JIT_W-1:0] r);
        longint unsigned sh;
        longint unsigned raw;
        longint unsigned scaled;
        sh = (att == '0) ? 64'd0 : 64'(att) - 64'd1;
        if (sh > 64'(SHIFT_MAX))
            sh = 64'(SHIFT_MAX);
        raw = longint'(base_ms) << sh;
        if (raw > 64'(ceiling_ms))
            raw = 64'(ceiling_ms);
        scaled = raw * (64'(FACTOR_BASE) + (r % 64'd41)) / 64'd100;
        // lower clamp first, so a zero ceiling still wins
        if (scaled < 64'd1)
            scaled = 64'd1;
        if (scaled > 64'(ceiling_ms))
            scaled = 64'(ceiling_ms);
        return DELAY_W'(scaled);
    endfunction

    function automatic backoff_snapshot_t apply_event(input logic [OP_W-1:0] op,
                                                      input logic [CH_W-1:0] ch);
        backoff_snapshot_t snap;
        logic [JIT_W-1:0]  s;
        snap = '0;
        if (ch >= NUM_CHANNELS) begin
            snap.reconnects = metered_fails;
            return snap;
        end
        if (op <= OP_RECONNECTING && !seeded[ch]) begin
            s = (seed_reg == '0) ? SEED_IF_ZERO : seed_reg;
            s = s ^ JIT_W'(ch);
            rng[ch] = (s == '0) ? STATE_IF_ZERO : s;
            seeded[ch] = 1'b1;
        end
        case (op)
            OP_CONNECTED: begin
                if (down[ch]) begin
                    snap.recovered = 1'b1;
                    restores[ch] = bump32(restores[ch]);
                end
                link_phase[ch] = PHASE_CONNECTED;
                tries[ch]      = '0;
                wait_ms[ch]    = '0;
                down[ch]       = 1'b0;
            end
            OP_FAILURE, OP_AGG_FAILURE: begin
                if (!down[ch]) begin
                    down[ch]    = 1'b1;
                    outages[ch] = bump32(outages[ch]);
                end
                if (tries[ch] < ATT_MAX)
                    tries[ch] = tries[ch] + 1'b1;
                link_phase[ch] = (tries[ch] == 1) ? PHASE_DEGRADED : PHASE_RECONNECTING;
                rng[ch]     = jitter_advance(rng[ch]);
                wait_ms[ch] = backoff_ms(tries[ch], rng[ch]);
                if (op == OP_FAILURE)
                    metered_fails = bump32(metered_fails);
            end
            OP_RECONNECTING: begin
                link_phase[ch] = PHASE_RECONNECTING;
            end
            default: ;
        endcase
        snap.phase         = link_phase[ch];
        snap.attempts      = tries[ch];
        snap.delay_ms      = wait_ms[ch];
        snap.interruptions = outages[ch];
        snap.recoveries    = restores[ch];
        snap.reconnects    = metered_fails;
        return snap;
    endfunction

    task automatic check_field(input string field, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            mismatch_total++;
        end
    endtask

    always @(posedge i_clk) begin
        backoff_snapshot_t want;
        backoff_snapshot_t due;
        if (!i_rst_n) begin
            seed_reg      = SEED_RESET;
            base_ms       = BASE_RESET;
            ceiling_ms    = MAX_RESET;
            metered_fails = '0;
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                seeded[i]     = 1'b0;
                link_phase[i] = PHASE_CONNECTED;
                tries[i]      = '0;
                wait_ms[i]    = '0;
                down[i]       = 1'b0;
                rng[i]        = '0;
                outages[i]    = '0;
                restores[i]   = '0;
            end
            snapshots_due.delete();
        end else begin
            // retire the oldest expectation before queuing a new one
            if (i_done) begin
                if (snapshots_due.size() == 0) begin
                    $error("result beat with no event outstanding");
                    mismatch_total++;
                end else begin
                    want = snapshots_due.pop_front();
                    check_field("recovered", 64'(want.recovered), 64'(i_recovered));
                    check_field("phase", 64'(want.phase), 64'(i_phase));
                    check_field("attempts", 64'(want.attempts), 64'(i_attempts));
                    check_field("retry_delay_ms", 64'(want.delay_ms),
                                64'(i_retry_delay_ms));
                    check_field("interruptions", 64'(want.interruptions),
                                64'(i_interruptions));
                    check_field("recoveries", 64'(want.recoveries), 64'(i_recoveries));
                    check_field("metered_failures", 64'(want.reconnects),
                                64'(i_metered_failures));
                    checked_total++;
                    if (32'(i_attempts) > peak_tries)
                        peak_tries = 32'(i_attempts);
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_JITTER_SEED: seed_reg   = i_cfg_data;
                    CFG_BASE_DELAY:  base_ms    = i_cfg_data[DELAY_W-1:0];
                    CFG_MAX_DELAY:   ceiling_ms = i_cfg_data[DELAY_W-1:0];
                    default: ;
                endcase
            end
            if (i_start && !i_busy) begin
                due = apply_event(i_operation, i_channel);
                snapshots_due = {snapshots_due, due};
            end
        end
        o_pending <= snapshots_due.size();
    end

endmodule

// File: tb/tb_top.sv
module tb_top;
    import cbr_pkg::*;

    // Codes the package leaves unnamed: the query operation and the unused
    // register slot (writes there must be ignored).
    localparam logic [OP_W-1:0]      OP_QUERY  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    localparam int unsigned RESET_CYCLES   = 11;
    localparam int unsigned RANDOM_PHASES  = 6;
    localparam int unsigned PHASE_EVENTS   = 230;
    localparam int unsigned DRAIN_CYCLES   = 12;   // a failure is the longest event
    localparam int unsigned WATCHDOG_LIMIT = 500;

    logic                  i_clk     = 1'b0;
    logic                  i_rst_n   = 1'b0;
    logic                  i_start   = 1'b0;
    logic [OP_W-1:0]       i_operation = '0;
    logic [CH_W-1:0]       i_channel = '0;
    logic                  i_cfg_we  = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    logic                  o_busy;
    logic                  o_done;
    logic                  o_recovered;
    logic [PHASE_W-1:0]    o_phase;
    logic [ATT_W-1:0]      o_attempts;
    logic [DELAY_W-1:0]    o_retry_delay_ms;
    logic [CNT_W-1:0]      o_interruptions;
    logic [CNT_W-1:0]      o_recoveries;
    logic [CNT_W-1:0]      o_metered_failures;

    int unsigned mismatches;
    int unsigned pending;
    int unsigned checked;
    int unsigned peak_attempts;

    int unsigned events_sent   = 0;
    int unsigned settings_used = 0;
    int unsigned quiet_cycles  = 0;

    always #5 i_clk = ~i_clk;

    channel_reconnect_backoff_core #(
        .NUM_CHANNELS(8)
    ) uut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_start             (i_start),
        .o_busy              (o_busy),
        .i_operation         (i_operation),
        .i_channel           (i_channel),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .o_done              (o_done),
        .o_recovered         (o_recovered),
        .o_phase             (o_phase),
        .o_attempts          (o_attempts),
        .o_retry_delay_ms    (o_retry_delay_ms),
        .o_interruptions     (o_interruptions),
        .o_recoveries        (o_recoveries),
        .o_metered_failures  (o_metered_failures)
    );

    backoff_snapshot_checker #(
        .NUM_CHANNELS(8)
    ) checker_i (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_start             (i_start),
        .i_busy              (o_busy),
        .i_operation         (i_operation),
        .i_channel           (i_channel),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .i_done              (o_done),
        .i_recovered         (o_recovered),
        .i_phase             (o_phase),
        .i_attempts          (o_attempts),
        .i_retry_delay_ms    (o_retry_delay_ms),
        .i_interruptions     (o_interruptions),
        .i_recoveries        (o_recoveries),
        .i_metered_failures  (o_metered_failures),
        .o_mismatches        (mismatches),
        .o_pending           (pending),
        .o_checked           (checked),
        .o_peak_attempts     (peak_attempts)
    );

    // Watchdog: any beat, in or out, or a register write counts as progress.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_start && !o_busy) || o_done || i_cfg_we) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("channel_reconnect_backoff_core verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Present one event and hold it until the block takes it. Start is left
    // high on return so the next event can follow back to back.
    task automatic send_event(input logic [OP_W-1:0] op, input logic [CH_W-1:0] ch);
        i_start     <= 1'b1;
        i_operation <= op;
        i_channel   <= ch;
        do @(posedge i_clk); while (o_busy);
        events_sent++;
    endtask

    // Drop start and wait until every snapshot has come back. The first edge
    // lets the checker's registered count see an event taken on the last edge.
    task automatic wait_idle();
        i_start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
    endtask

    // Load all three registers plus the spare slot. Upper data bits of the
    // delay registers carry noise; only the low 16 bits may matter.
    task automatic load_settings(input logic [JIT_W-1:0] seed,
                                 input logic [DELAY_W-1:0] base,
                                 input logic [DELAY_W-1:0] ceiling);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_JITTER_SEED;
        i_cfg_data  <= seed;
        @(posedge i_clk);
        i_cfg_index <= CFG_BASE_DELAY;
        i_cfg_data  <= {16'($urandom), 32'($urandom), base};
        @(posedge i_clk);
        i_cfg_index <= CFG_MAX_DELAY;
        i_cfg_data  <= {16'($urandom), 32'($urandom), ceiling};
        @(posedge i_clk);
        i_cfg_index <= CFG_SPARE;
        i_cfg_data  <= {$urandom, $urandom};
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        settings_used++;
    endtask

    // Idle the sender between bursts; a zero gap keeps start high.
    task automatic burst_gap();
        int unsigned gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        if (gap != 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // One random phase. Half the events hammer a hot channel with failures
    // so the attempt count climbs to saturation; the rest are noise over all
    // channels and all operation codes, undefined ones included.
    task automatic random_phase(input int unsigned count);
        logic [CH_W-1:0] hot;
        logic [OP_W-1:0] op;
        logic [CH_W-1:0] ch;
        int unsigned     pick;
        int unsigned     burst_left;
        hot        = CH_W'($urandom_range(0, 7));
        burst_left = $urandom_range(1, 20);
        repeat (count) begin
            if ($urandom_range(0, 1) == 1) begin
                ch   = hot;
                pick = $urandom_range(0, 99);
                if (pick == 0)
                    op = OP_CONNECTED;
                else if (pick < 60)
                    op = OP_FAILURE;
                else if (pick < 90)
                    op = OP_AGG_FAILURE;
                else if (pick < 95)
                    op = OP_RECONNECTING;
                else
                    op = OP_QUERY;
            end else begin
                ch = CH_W'($urandom_range(0, 7));
                op = OP_W'($urandom_range(0, 7));
            end
            send_event(op, ch);
            burst_left--;
            if (burst_left == 0) begin
                burst_gap();
                burst_left = $urandom_range(1, 20);
            end
        end
    endtask

    initial begin
        logic [OP_W-1:0] op;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part under the reset settings. A query on a fresh channel
        // must not seed it; connected without an outage recovers nothing.
        send_event(OP_QUERY, 3'd0);
        send_event(OP_CONNECTED, 3'd0);
        send_event(OP_FAILURE, 3'd0);        // opens outage, degraded
        send_event(OP_AGG_FAILURE, 3'd0);    // second attempt, not metered
        send_event(OP_RECONNECTING, 3'd0);
        send_event(OP_QUERY, 3'd0);
        op = OP_QUERY;
        repeat (3) begin                     // undefined codes act as a query
            op = op + 1'b1;
            send_event(op, 3'd0);
        end
        send_event(OP_CONNECTED, 3'd0);      // closes the outage
        send_event(OP_CONNECTED, 3'd0);      // nothing left to close
        send_event(OP_RECONNECTING, 3'd1);   // reconnecting seeds a channel too
        send_event(OP_FAILURE, 3'd1);
        send_event(OP_CONNECTED, 3'd1);
        send_event(OP_QUERY, 3'd7);
        send_event(OP_FAILURE, 3'd7);
        send_event(OP_AGG_FAILURE, 3'd7);
        send_event(OP_CONNECTED, 3'd7);

        // Zero seed falls back to the default mix; largest delays.
        load_settings('0, '1, '1);
        repeat (3) send_event(OP_FAILURE, 3'd2);

        // Seed equal to the channel number zeroes the seed mix, which falls back to a
        // fixed nonzero state; a zero base clamps up to one.
        load_settings(JIT_W'(5), '0, MAX_RESET);
        send_event(OP_FAILURE, 3'd5);
        send_event(OP_AGG_FAILURE, 3'd3);

        // Zero ceiling wins over the lower clamp.
        load_settings('1, BASE_RESET, '0);
        send_event(OP_FAILURE, 3'd4);
        send_event(OP_FAILURE, 3'd6);

        load_settings('1, DELAY_W'(1), DELAY_W'(1));
        send_event(OP_FAILURE, 3'd4);

        // Random phases, each under its own register setting.
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0: load_settings({$urandom, $urandom}, '1, '1);
                1: load_settings({$urandom, $urandom}, '0,
                                 DELAY_W'($urandom_range(1, 65535)));
                2: load_settings({$urandom, $urandom},
                                 DELAY_W'($urandom_range(1, 65535)), '0);
                3: load_settings({$urandom, $urandom}, DELAY_W'(1), DELAY_W'(1));
                4: load_settings({$urandom, $urandom}, DELAY_W'($urandom_range(1, 2000)),
                                 DELAY_W'($urandom_range(1, 65535)));
                default: load_settings({$urandom, $urandom}, BASE_RESET, MAX_RESET);
            endcase
            random_phase(PHASE_EVENTS);
        end

        // Drain, then give a stray late beat time to show up.
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Run: %0d events under %0d register settings, %0d snapshots compared",
                 events_sent, settings_used, checked);
        $display("Deepest backoff seen: %0d attempts, %0d mismatches",
                 peak_attempts, mismatches);
        if (mismatches == 0 && pending == 0) begin
            $display("channel_reconnect_backoff_core verification clean");
        end else begin
            $display("channel_reconnect_backoff_core verification failed");
        end
        $finish;
    end

endmodule
